FILE: design/kbd_pkg.sv
// ----------------------------------------------------------------------------
// kbd_pkg: shared types, constants and key tables for the scancode decoder
// Holds the set-1 key codes, command codes, the two key maps and the
// control structs passed between the decoder and the character queue.
// ----------------------------------------------------------------------------
package kbd_pkg;

  // Command codes of an input word
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Set-1 scancode fields
  localparam int unsigned RELEASE_BIT = 7;
  localparam int unsigned KEY_W       = 7;
  localparam int unsigned CHAR_W      = 8;

  // Modifier and special keys (release bit stripped)
  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1D;
  localparam logic [KEY_W-1:0] KEY_ALT    = 7'h38;
  localparam logic [KEY_W-1:0] KEY_DEL    = 7'h53;

  localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_DEL  = 8'h7F;

  // Per-word request from the decoder to the queue
  typedef struct packed {
    logic              step;    // an input word leaves the input register
    logic              push;    // write ch into the queue
    logic              pop;     // read one character
    logic [CHAR_W-1:0] ch;
    logic              reboot;
  } kbd_req_t;

  // Per-word outcome reported by the queue
  typedef struct packed {
    logic queued;
    logic dropped;
    logic popped;
  } kbd_stat_t;

  // Unshifted key map
  function automatic logic [CHAR_W-1:0] plain_map(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    unique case (key)
      7'h01:   ch = 8'h1B;
      7'h02:   ch = "1";
      7'h03:   ch = "2";
      7'h04:   ch = "3";
      7'h05:   ch = "4";
      7'h06:   ch = "5";
      7'h07:   ch = "6";
      7'h08:   ch = "7";
      7'h09:   ch = "8";
      7'h0A:   ch = "9";
      7'h0B:   ch = "0";
      7'h0E:   ch = 8'h08;
      7'h0F:   ch = 8'h09;
      7'h10:   ch = "q";
      7'h11:   ch = "w";
      7'h12:   ch = "e";
      7'h13:   ch = "r";
      7'h14:   ch = "t";
      7'h15:   ch = "y";
      7'h16:   ch = "u";
      7'h17:   ch = "i";
      7'h18:   ch = "o";
      7'h19:   ch = "p";
      7'h1C:   ch = 8'h0A;
      7'h1E:   ch = "a";
      7'h1F:   ch = "s";
      7'h20:   ch = "d";
      7'h21:   ch = "f";
      7'h22:   ch = "g";
      7'h23:   ch = "h";
      7'h24:   ch = "j";
      7'h25:   ch = "k";
      7'h26:   ch = "l";
      7'h28:   ch = 8'h27;
      7'h2B:   ch = 8'h27;
      7'h2C:   ch = "z";
      7'h2D:   ch = "x";
      7'h2E:   ch = "c";
      7'h2F:   ch = "v";
      7'h30:   ch = "b";
      7'h31:   ch = "n";
      7'h32:   ch = "m";
      7'h33:   ch = ",";
      7'h34:   ch = ".";
      7'h35:   ch = "-";
      7'h39:   ch = " ";
      KEY_DEL: ch = CHAR_DEL;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  // Shifted key map
  function automatic logic [CHAR_W-1:0] shift_map(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    unique case (key)
      7'h01:   ch = 8'h1B;
      7'h02:   ch = "!";
      7'h03:   ch = 8'h22;
      7'h04:   ch = "#";
      7'h05:   ch = "$";
      7'h06:   ch = "%";
      7'h07:   ch = "&";
      7'h08:   ch = "/";
      7'h09:   ch = "(";
      7'h0A:   ch = ")";
      7'h0B:   ch = "=";
      7'h0E:   ch = 8'h08;
      7'h0F:   ch = 8'h09;
      7'h10:   ch = "Q";
      7'h11:   ch = "W";
      7'h12:   ch = "E";
      7'h13:   ch = "R";
      7'h14:   ch = "T";
      7'h15:   ch = "Y";
      7'h16:   ch = "U";
      7'h17:   ch = "I";
      7'h18:   ch = "O";
      7'h19:   ch = "P";
      7'h1C:   ch = 8'h0A;
      7'h1E:   ch = "A";
      7'h1F:   ch = "S";
      7'h20:   ch = "D";
      7'h21:   ch = "F";
      7'h22:   ch = "G";
      7'h23:   ch = "H";
      7'h24:   ch = "J";
      7'h25:   ch = "K";
      7'h26:   ch = "L";
      7'h28:   ch = 8'h27;
      7'h2B:   ch = 8'h27;
      7'h2C:   ch = "Z";
      7'h2D:   ch = "X";
      7'h2E:   ch = "C";
      7'h2F:   ch = "V";
      7'h30:   ch = "B";
      7'h31:   ch = "N";
      7'h32:   ch = "M";
      7'h33:   ch = ";";
      7'h34:   ch = ":";
      7'h35:   ch = "_";
      7'h39:   ch = " ";
      KEY_DEL: ch = CHAR_DEL;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/kbd_in_if.sv
// ----------------------------------------------------------------------------
// kbd_in_if: input word channel of the scancode decoder
// Carries a command, a raw scancode and the halted flag with valid/ready.
// ----------------------------------------------------------------------------
interface kbd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] scancode;
  logic       system_halted;

  modport source (output valid, command, scancode, system_halted, input ready);
  modport sink   (input valid, command, scancode, system_halted, output ready);
endinterface

FILE: design/kbd_out_if.sv
// ----------------------------------------------------------------------------
// kbd_out_if: result word channel of the scancode decoder
// Carries one result word per input word with valid/ready.
// ----------------------------------------------------------------------------
interface kbd_out_if #(
  parameter int unsigned LEVEL_W = 7
);
  logic               valid;
  logic               ready;
  logic               byte_valid;
  logic [7:0]         read_byte;
  logic               char_queued;
  logic               char_dropped;
  logic               reboot_request;
  logic [LEVEL_W-1:0] queue_level;

  modport source (output valid, byte_valid, read_byte, char_queued, char_dropped,
                  reboot_request, queue_level, input ready);
  modport sink   (input valid, byte_valid, read_byte, char_queued, char_dropped,
                  reboot_request, queue_level, output ready);
endinterface

FILE: design/kbd_decode.sv
// ----------------------------------------------------------------------------
// kbd_decode: modifier tracking and key mapping
// Holds the shift, ctrl and alt flags and turns the registered input word
// into a queue request and a reboot flag.
// ----------------------------------------------------------------------------
module kbd_decode
  import kbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              command,
  input  logic [7:0]        scancode,
  input  logic              system_halted,
  output kbd_req_t          req
);

  logic             shift_r, shift_nxt;
  logic             ctrl_r, ctrl_nxt;
  logic             alt_r, alt_nxt;
  logic [KEY_W-1:0] key;
  logic             press;
  logic             is_scan;
  logic             is_shift, is_ctrl, is_alt, is_mod;
  logic [CHAR_W-1:0] ch;

  // Split the scancode
  assign key      = scancode[KEY_W-1:0];
  assign press    = ~scancode[RELEASE_BIT];
  assign is_scan  = (command == CMD_SCAN);
  assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
  assign is_ctrl  = (key == KEY_CTRL);
  assign is_alt   = (key == KEY_ALT);
  assign is_mod   = is_shift | is_ctrl | is_alt;
  assign ch       = shift_r ? shift_map(key) : plain_map(key);

  // Update modifier flags on the word that leaves this cycle
  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    if (step && is_scan) begin
      if (is_shift) shift_nxt = press;
      if (is_ctrl)  ctrl_nxt  = press;
      if (is_alt)   alt_nxt   = press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
    end
  end

  // Build the queue request
  always_comb begin
    req.step   = step;
    req.pop    = step && (command == CMD_READ);
    req.push   = step && is_scan && !is_mod && !system_halted && press &&
                 (ch != CHAR_NONE);
    req.ch     = ch;
    req.reboot = step && is_scan && !is_mod && (key == KEY_DEL) && ctrl_r && alt_r;
  end

endmodule

FILE: design/kbd_queue.sv
// ----------------------------------------------------------------------------
// kbd_queue: character FIFO
// Circular buffer with write and read pointers and a fill count; the read
// byte is registered and the fill count is the level reported downstream.
// ----------------------------------------------------------------------------
module kbd_queue
  import kbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kbd_req_t           req,
  output kbd_stat_t          stat,
  output logic [CHAR_W-1:0]  rd_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LEVEL_W-1:0] FULL_LVL  = LEVEL_W'(QUEUE_DEPTH);

  logic [CHAR_W-1:0]  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LEVEL_W-1:0] count_r, count_nxt;
  logic [CHAR_W-1:0]  rd_data_r;
  logic               full, empty;
  logic               push_ok, pop_ok;

  assign full    = (count_r == FULL_LVL);
  assign empty   = (count_r == '0);
  assign push_ok = req.push && !full;
  assign pop_ok  = req.pop && !empty;

  assign stat.queued  = push_ok;
  assign stat.dropped = req.push && full;
  assign stat.popped  = pop_ok;

  // Advance pointers with wrap at the last slot
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= req.ch;
    end
  end

  // Register read data; zero when nothing is popped
  always_ff @(posedge clk) begin
    if (req.step) begin
      rd_data_r <= pop_ok ? mem[rd_ptr_r] : CHAR_NONE;
    end
  end

  assign rd_data = rd_data_r;
  assign level   = count_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_LVL)
    else $error("queue count above depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.push && req.pop))
    else $error("push and pop requested together");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> count_r == $past(count_r) + 1'b1)
    else $error("count did not grow on push");

  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> count_r == $past(count_r) - 1'b1)
    else $error("count did not shrink on pop");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wr_ptr_r == rd_ptr_r)
    else $error("pointers differ on empty queue");

endmodule

FILE: design/keyboard_scancode_decoder.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder: set-1 scancodes to ASCII through a character FIFO
//
// in_ch carries one word per step: a scancode (command 0) or a read request
// (command 1). out_ch returns exactly one result word for every input word,
// in order. Words move on valid && ready at the rising edge of clk.
// An accepted word is held in the input register; the key map, modifier update
// and one FIFO access then land in the result register. Throughput is one
// word per cycle while out_ch.ready stays high; each word makes at most one
// write or one read of the character memory.
// in_ch.ready stays high while either register is empty or the result is taken,
// so a stalled receiver holds both registers and back-pressures the source
// after one extra word. queue_level reports the FIFO fill count after the
// step; its width is $clog2(QUEUE_DEPTH+1), so out_ch must be built with
// LEVEL_W set to match. Synchronous reset (rst_n low) clears the modifier
// flags, FIFO pointers and both valid bits; FIFO contents are not cleared.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder
  import kbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  kbd_in_if.sink      in_ch,
  kbd_out_if.source   out_ch
);

  localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  logic               in_valid_r;
  logic               command_r;
  logic [7:0]         scancode_r;
  logic               halted_r;
  logic               out_valid_r;
  logic               byte_valid_r;
  logic               queued_r;
  logic               dropped_r;
  logic               reboot_r;
  logic               advance;
  logic               accept;
  kbd_req_t           req;
  kbd_stat_t          stat;
  logic [CHAR_W-1:0]  rd_data;
  logic [LEVEL_W-1:0] level;

  // Handshake
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      command_r  <= in_ch.command;
      scancode_r <= in_ch.scancode;
      halted_r   <= in_ch.system_halted;
    end
  end

  kbd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_valid_r && advance),
    .command       (command_r),
    .scancode      (scancode_r),
    .system_halted (halted_r),
    .req           (req)
  );

  kbd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .stat    (stat),
    .rd_data (rd_data),
    .level   (level)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_valid_r <= stat.popped;
      queued_r     <= stat.queued;
      dropped_r    <= stat.dropped;
      reboot_r     <= req.reboot;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_valid     = byte_valid_r;
  assign out_ch.read_byte      = rd_data;
  assign out_ch.char_queued    = queued_r;
  assign out_ch.char_dropped   = dropped_r;
  assign out_ch.reboot_request = reboot_r;
  assign out_ch.queue_level    = level;

endmodule

FILE: test/kbd_decoder_checker.sv
// ----------------------------------------------------------------------------
// kbd_decoder_checker: result predictor and comparator for the scancode decoder
// Watches both channels of the decoder, keeps its own copy of the modifier
// flags and the character queue, predicts one result word per accepted input
// word and compares every accepted result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kbd_decoder_checker
  import kbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned LEVEL_W     = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel, observed
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_command,
  input  logic [7:0]         in_scancode,
  input  logic               in_system_halted,
  // result channel, observed
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_byte_valid,
  input  logic [7:0]         out_read_byte,
  input  logic               out_char_queued,
  input  logic               out_char_dropped,
  input  logic               out_reboot_request,
  input  logic [LEVEL_W-1:0] out_queue_level,
  // to the testbench top
  output int                 fail_count,
  output int                 results_waiting
);

  typedef struct packed {
    logic               byte_valid;
    logic [7:0]         read_byte;
    logic               char_queued;
    logic               char_dropped;
    logic               reboot_request;
    logic [LEVEL_W-1:0] queue_level;
  } kbd_result_t;

  // Key maps, indexed by the scancode without its release bit
  logic [CHAR_W-1:0] plain_chars   [128];
  logic [CHAR_W-1:0] shifted_chars [128];

  // Model state
  logic              shift_down;
  logic              ctrl_down;
  logic              alt_down;
  logic [CHAR_W-1:0] char_mem [QUEUE_DEPTH];
  int unsigned       wr_slot;
  int unsigned       rd_slot;
  int unsigned       char_count;

  kbd_result_t pending_results[$];

  // Fill a run of consecutive keys from two character strings
  task automatic load_row(input int first_key, input string plain, input string shifted);
    for (int i = 0; i < plain.len(); i++) begin
      plain_chars[first_key + i]   = plain[i];
      shifted_chars[first_key + i] = shifted[i];
    end
  endtask

  // Set a key that maps to the same byte with or without shift
  task automatic load_key(input int key, input logic [CHAR_W-1:0] ch);
    plain_chars[key]   = ch;
    shifted_chars[key] = ch;
  endtask

  initial begin
    foreach (plain_chars[i]) begin
      plain_chars[i]   = CHAR_NONE;
      shifted_chars[i] = CHAR_NONE;
    end
    load_row(8'h02, "1234567890", "!\"#$%&/()=");
    load_row(8'h10, "qwertyuiop", "QWERTYUIOP");
    load_row(8'h1E, "asdfghjkl", "ASDFGHJKL");
    load_row(8'h2C, "zxcvbnm,.-", "ZXCVBNM;:_");
    load_key(8'h01, 8'h1B);
    load_key(8'h0E, 8'h08);
    load_key(8'h0F, 8'h09);
    load_key(8'h1C, 8'h0A);
    load_key(8'h28, 8'h27);
    load_key(8'h2B, 8'h27);
    load_key(8'h39, 8'h20);
    load_key(KEY_DEL, CHAR_DEL);
    shift_down = 1'b0;
    ctrl_down  = 1'b0;
    alt_down   = 1'b0;
    wr_slot    = 0;
    rd_slot    = 0;
    char_count = 0;
  end

  // Advance the model by one input word and return the result it yields
  function automatic kbd_result_t decode_word(input logic cmd, input logic [7:0] code,
                                              input logic halted);
    kbd_result_t       res;
    logic [KEY_W-1:0]  key;
    logic              press;
    logic [CHAR_W-1:0] ch;
    res   = '0;
    key   = code[KEY_W-1:0];
    press = !code[RELEASE_BIT];
    if (cmd == CMD_READ) begin
      // pop one byte, or report empty and leave the queue alone
      if (char_count != 0) begin
        res.byte_valid = 1'b1;
        res.read_byte  = char_mem[rd_slot];
        rd_slot        = (rd_slot + 1) % QUEUE_DEPTH;
        char_count--;
      end
    end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
      shift_down = press;
    end else if (key == KEY_CTRL) begin
      ctrl_down = press;
    end else if (key == KEY_ALT) begin
      alt_down = press;
    end else begin
      // ctrl-alt-del fires on press and release, halted or not
      if (key == KEY_DEL && ctrl_down && alt_down) res.reboot_request = 1'b1;
      if (!halted && press) begin
        ch = shift_down ? shifted_chars[key] : plain_chars[key];
        if (ch != CHAR_NONE) begin
          if (char_count >= QUEUE_DEPTH) begin
            res.char_dropped = 1'b1;
          end else begin
            char_mem[wr_slot] = ch;
            wr_slot           = (wr_slot + 1) % QUEUE_DEPTH;
            char_count++;
            res.char_queued = 1'b1;
          end
        end
      end
    end
    res.queue_level = char_count[LEVEL_W-1:0];
    return res;
  endfunction

  // Compare one field, four-state, and count a mismatch
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      fail_count++;
    end
  endfunction

  // Pop the oldest prediction on each result word, push one per input word
  always @(posedge clk) begin
    kbd_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with no input word outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
          check_field("read_byte", want.read_byte, out_read_byte);
          check_field("char_queued", 8'(want.char_queued), 8'(out_char_queued));
          check_field("char_dropped", 8'(want.char_dropped), 8'(out_char_dropped));
          check_field("reboot_request", 8'(want.reboot_request), 8'(out_reboot_request));
          check_field("queue_level", 8'(want.queue_level), 8'(out_queue_level));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(decode_word(in_command, in_scancode, in_system_halted));
      end
      results_waiting = pending_results.size();
    end
  end

endmodule

FILE: test/keyboard_scancode_decoder_test.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_test: stimulus and verdict for the scancode decoder
// Drives directed key sequences and then random typing, queue fill and drain,
// ctrl-alt-del combos and noise, with random gaps and stalls on both channels
// and one long receiver hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyboard_scancode_decoder_test;
  import kbd_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 64;
  localparam int unsigned LEVEL_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int          CLK_PERIOD      = 10;
  localparam int          RESET_CYCLES    = 9;
  localparam int          RANDOM_WORDS    = 750;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          IDLE_LIMIT      = 3000;
  localparam int          TAIL_CYCLES     = 10;

  typedef enum int {
    PH_TYPE,
    PH_COMBO,
    PH_NOISE,
    PH_FILL,
    PH_DRAIN
  } phase_t;

  logic clk = 1'b0;
  logic rst_n;

  int   fail_count;
  int   results_waiting;
  int   words_sent;
  int   idle_cycles;
  bit   sender_steady;
  bit   receiver_steady;
  bit   hold_off_req;

  kbd_in_if                        in_ch ();
  kbd_out_if #(.LEVEL_W(LEVEL_W))  out_ch ();

  keyboard_scancode_decoder #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kbd_decoder_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LEVEL_W    (LEVEL_W)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_command         (in_ch.command),
    .in_scancode        (in_ch.scancode),
    .in_system_halted   (in_ch.system_halted),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_byte_valid     (out_ch.byte_valid),
    .out_read_byte      (out_ch.read_byte),
    .out_char_queued    (out_ch.char_queued),
    .out_char_dropped   (out_ch.char_dropped),
    .out_reboot_request (out_ch.reboot_request),
    .out_queue_level    (out_ch.queue_level),
    .fail_count         (fail_count),
    .results_waiting    (results_waiting)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random key that maps to a character
  function automatic logic [KEY_W-1:0] char_key();
    case ($urandom_range(0, 4))
      0:       return KEY_W'(8'h02 + $urandom_range(0, 9));
      1:       return KEY_W'(8'h10 + $urandom_range(0, 9));
      2:       return KEY_W'(8'h1E + $urandom_range(0, 8));
      3:       return KEY_W'(8'h2C + $urandom_range(0, 9));
      default: begin
        case ($urandom_range(0, 7))
          0:       return 7'h01;
          1:       return 7'h0E;
          2:       return 7'h0F;
          3:       return 7'h1C;
          4:       return 7'h28;
          5:       return 7'h2B;
          6:       return 7'h39;
          default: return KEY_DEL;
        endcase
      end
    endcase
  endfunction

  // Offer one word and hold it until the decoder takes it
  task automatic send_word(input logic cmd, input logic [7:0] code, input logic halted);
    int gap;
    gap = sender_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.scancode      <= code;
    in_ch.system_halted <= halted;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic press_key(input logic [KEY_W-1:0] key, input logic halted);
    send_word(CMD_SCAN, {1'b0, key}, halted);
  endtask

  task automatic release_key(input logic [KEY_W-1:0] key, input logic halted);
    send_word(CMD_SCAN, {1'b1, key}, halted);
  endtask

  task automatic read_char();
    send_word(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Typing: optional shift around a press and release, reads in between
  task automatic type_keys(input int n);
    logic             shifted;
    logic             halted;
    logic [KEY_W-1:0] shift_key;
    logic [KEY_W-1:0] key;
    repeat (n) begin
      shifted   = ($urandom_range(0, 3) == 0);
      halted    = ($urandom_range(0, 9) == 0);
      shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
      key       = char_key();
      if (shifted) press_key(shift_key, halted);
      press_key(key, halted);
      release_key(key, halted);
      if (shifted) release_key(shift_key, halted);
      if ($urandom_range(0, 2) == 0) read_char();
    end
  endtask

  // Ctrl and alt in random order around delete events, sometimes only one held
  task automatic combo_keys(input int n);
    logic halted;
    bit   with_ctrl;
    bit   with_alt;
    repeat (n) begin
      halted    = ($urandom_range(0, 3) == 0);
      with_ctrl = ($urandom_range(0, 4) != 0);
      with_alt  = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 1)) begin
        if (with_ctrl) press_key(KEY_CTRL, halted);
        if (with_alt) press_key(KEY_ALT, halted);
      end else begin
        if (with_alt) press_key(KEY_ALT, halted);
        if (with_ctrl) press_key(KEY_CTRL, halted);
      end
      if ($urandom_range(0, 2) == 0) press_key(KEY_LSHIFT, halted);
      press_key(KEY_DEL, halted);
      if ($urandom_range(0, 1)) press_key(char_key(), halted);
      release_key(KEY_DEL, halted);
      release_key(KEY_LSHIFT, halted);
      if ($urandom_range(0, 1)) begin
        release_key(KEY_CTRL, halted);
        release_key(KEY_ALT, halted);
      end else begin
        release_key(KEY_ALT, halted);
        release_key(KEY_CTRL, halted);
      end
      if ($urandom_range(0, 1)) read_char();
    end
  endtask

  // Stimulus
  initial begin
    phase_t phase;
    bit     first_fill;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_SCAN;
    in_ch.scancode      <= 8'h00;
    in_ch.system_halted <= 1'b0;
    words_sent    = 0;
    sender_steady = 1'b0;
    hold_off_req  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read on empty, extremes of the scancode, shift mapping
    send_word(CMD_READ, 8'hFF, 1'b1);
    send_word(CMD_SCAN, 8'h00, 1'b0);
    press_key(7'h02, 1'b0);
    press_key(KEY_LSHIFT, 1'b0);
    press_key(7'h10, 1'b0);
    release_key(KEY_RSHIFT, 1'b0);
    send_word(CMD_SCAN, 8'h7F, 1'b0);
    send_word(CMD_SCAN, 8'hFF, 1'b0);
    send_word(CMD_SCAN, 8'h80, 1'b0);
    // ctrl-alt-del on press, on release and while halted
    press_key(KEY_CTRL, 1'b0);
    press_key(KEY_ALT, 1'b0);
    press_key(KEY_DEL, 1'b0);
    release_key(KEY_DEL, 1'b0);
    press_key(KEY_DEL, 1'b1);
    press_key(7'h1E, 1'b1);
    release_key(KEY_CTRL, 1'b0);
    release_key(KEY_ALT, 1'b0);
    press_key(KEY_DEL, 1'b0);
    // drain past empty
    repeat (5) read_char();

    // random part: fill against a held receiver first, then drain
    hold_off_req = 1'b1;
    first_fill   = 1'b1;
    while (words_sent < RANDOM_WORDS + 25) begin
      if (first_fill) begin
        phase      = PH_FILL;
        first_fill = 1'b0;
      end else if (phase == PH_FILL) begin
        phase = PH_DRAIN;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: phase = PH_TYPE;
          7, 8, 9:             phase = PH_COMBO;
          10, 11, 12:          phase = PH_NOISE;
          13, 14, 15:          phase = PH_FILL;
          default:             phase = PH_DRAIN;
        endcase
      end
      if ($urandom_range(0, 3) == 0) sender_steady = !sender_steady;
      case (phase)
        PH_TYPE:  type_keys($urandom_range(5, 15));
        PH_COMBO: combo_keys($urandom_range(1, 4));
        PH_NOISE: begin
          repeat ($urandom_range(10, 30)) begin
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end
        end
        PH_FILL: begin
          repeat (QUEUE_DEPTH + $urandom_range(2, 8)) press_key(char_key(), 1'b0);
        end
        default: begin
          repeat (QUEUE_DEPTH + $urandom_range(1, 6)) read_char();
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    // wait for every result word, then let the pipeline settle
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, steady stretches and one long hold-off
  initial begin
    int stall;
    out_ch.ready    <= 1'b0;
    receiver_steady = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
        stall = 1 + gap_len();
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) receiver_steady = !receiver_steady;
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
